// ----- rtl/gfs_pkg.sv -----
// ---------------------------------------------------------------------------
// gfs_pkg
// Shared types and constants of the gradient flux stencil.
// ---------------------------------------------------------------------------
package gfs_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Register reset values and limits
    localparam logic [10:0] DEF_WIDTH  = 11'd640;
    localparam logic [12:0] DEF_HEIGHT = 13'd480;
    localparam int          MAX_HEIGHT = 4096;
    localparam int          DIM_W      = 13;

    // Data widths
    localparam int DIST_W = 16;
    localparam int GRAD_W = 20;
    localparam int FLUX_W = 24;

    // round(sqrt2 * 2^31)
    localparam logic signed [32:0] SQRT2_Q31 = 33'sd3037000500;

    // Output queue depth
    localparam int OUT_DEPTH = 8;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance_value;
        logic                     is_flush;
    } t_in_item;

    typedef struct packed {
        logic signed [FLUX_W-1:0] flux_value;
        logic [9:0]               pixel_x;
        logic [11:0]              pixel_y;
        logic                     last_of_frame;
    } t_result;

    // Neighbors that fall outside the image
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_border;

    typedef struct packed {
        logic signed [DIST_W-1:0] top;
        logic signed [DIST_W-1:0] mid;
        logic signed [DIST_W-1:0] bot;
    } t_dcol;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    typedef struct packed {
        t_grad top;
        t_grad mid;
        t_grad bot;
    } t_gcol;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [9:0] x;
        logic [11:0] y;
        t_border    border;
    } t_flux_meta;

endpackage

// ----- rtl/gfs_if.sv -----
// ---------------------------------------------------------------------------
// gfs_in_if / gfs_out_if
// Valid/ready stream channels for pixel requests and flux results.
// ---------------------------------------------------------------------------
interface gfs_in_if;
    logic              valid;
    logic              ready;
    gfs_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gfs_out_if;
    logic             valid;
    logic             ready;
    gfs_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/gfs_ram.sv -----
// ---------------------------------------------------------------------------
// gfs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gradient_flux_stencil.sv -----
// ---------------------------------------------------------------------------
// gradient_flux_stencil
// Sobel gradient of a distance map followed by the outward flux average.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries distance-map pixels (signed Q12.4) in raster order; a
//   request with is_flush set carries no pixel and only pushes the pipeline
//   (it is ignored while pixels of the frame are still expected).
//   o_out carries one flux result (signed Q12.12, saturated) with its pixel
//   position; last_of_frame marks the final pixel of the frame.
//   The result for pixel p is produced by request p + 2*W + 2 of the frame,
//   so 2*W + 2 flush requests drain a frame. A result passes the stage B, C,
//   D and E registers and the output queue to o_out. Throughput is one
//   request per cycle while i_in.ready is high: each request does at most
//   one read and one write in each of the two line memories (distance rows
//   and gradient rows). The sqrt2 product takes its own pipeline stage.
//   Results go into an eight-entry output queue; i_in.ready drops only when
//   the queue plus the requests in flight could fill it, so a stalled
//   receiver holds back the sender and nothing is lost. Reset clears the
//   position counters, pipeline and queue and sets the frame to 640 x 480;
//   the line memories need no clearing. Width and height are written through
//   the i_cfg port between frames by the user; the block does not enforce it.
// ---------------------------------------------------------------------------
module gradient_flux_stencil #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gfs_in_if.sink                         i_in,
    gfs_out_if.source                      o_out
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NW = $clog2(MAX_WIDTH * gfs_pkg::MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int QW = $clog2(gfs_pkg::OUT_DEPTH);
    localparam int DW = gfs_pkg::DIST_W;
    localparam int GW = gfs_pkg::GRAD_W;

    // -----------------------------------------------------------------------
    // Configuration registers and derived frame limits
    // -----------------------------------------------------------------------
    logic [10:0] r_width;
    logic [12:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gfs_pkg::DEF_WIDTH;
            r_height <= gfs_pkg::DEF_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gfs_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[10:0];
                gfs_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [12:0] clamp_w(logic [10:0] raw);
        logic [12:0] v;
        v = {2'b00, raw};
        if (v < 13'd3) return 13'd3;
        if (v > 13'(MAX_WIDTH)) return 13'(MAX_WIDTH);
        return v;
    endfunction

    function automatic logic [12:0] clamp_h(logic [12:0] raw);
        if (raw < 13'd3) return 13'd3;
        if (raw > 13'(gfs_pkg::MAX_HEIGHT)) return 13'(gfs_pkg::MAX_HEIGHT);
        return raw;
    endfunction

    logic [12:0]   n_w, n_h;
    logic [25:0]   n_prod;
    logic [NW-1:0] n_pix, n_wx;

    assign n_w    = clamp_w(r_width);
    assign n_h    = clamp_h(r_height);
    assign n_prod = n_w * n_h;
    assign n_pix  = NW'(n_prod);
    assign n_wx   = NW'(n_w);

    logic [CW-1:0] r_wm1;
    logic [11:0]   r_hm1;
    logic [NW-1:0] r_pix, r_t_g, r_t_ge, r_t_f, r_t_last;

    // Registered from the configuration registers, following them in the next cycle
    always_ff @(posedge i_clk) begin
        r_wm1    <= CW'(n_w - 13'd1);
        r_hm1    <= 12'(n_h - 13'd1);
        r_pix    <= n_pix;
        r_t_g    <= n_wx + NW'(1);
        r_t_ge   <= n_pix + n_wx + NW'(1);
        r_t_f    <= (n_wx << 1) + NW'(2);
        r_t_last <= n_pix + (n_wx << 1) + NW'(1);
    end

    // -----------------------------------------------------------------------
    // Stage A: request intake, position counters, memory reads
    // -----------------------------------------------------------------------
    logic [NW-1:0] r_n, n_n;
    logic [CW-1:0] r_nc, n_nc, r_gc, n_gc, r_fc, n_fc;
    logic [11:0]   r_gr, n_gr, r_fr, n_fr;

    logic a_acc, a_pix, a_proc, a_gact, a_gcomp, a_fact, a_last;
    logic [3:0] a_busy;
    logic [QW:0] r_cnt;
    logic r_b_v, r_c_v, r_d_v, r_e_v;

    assign a_busy     = 4'(r_cnt) + 4'(r_b_v) + 4'(r_c_v) + 4'(r_d_v) + 4'(r_e_v);
    assign i_in.ready = a_busy < 4'(gfs_pkg::OUT_DEPTH);

    assign a_acc   = i_in.valid & i_in.ready;
    assign a_pix   = r_n < r_pix;
    assign a_proc  = a_acc & !(a_pix & i_in.payload.is_flush);
    assign a_gact  = r_n >= r_t_g;
    assign a_gcomp = a_gact & (r_n < r_t_ge);
    assign a_fact  = r_n >= r_t_f;
    assign a_last  = r_n == r_t_last;

    // Next counter values
    always_comb begin
        n_n  = r_n + NW'(1);
        n_nc = (r_nc == r_wm1) ? '0 : r_nc + CW'(1);
        n_gc = r_gc;
        n_gr = r_gr;
        n_fc = r_fc;
        n_fr = r_fr;
        if (a_gact) begin
            n_gc = (r_gc == r_wm1) ? '0 : r_gc + CW'(1);
            n_gr = (r_gc == r_wm1) ? r_gr + 12'd1 : r_gr;
        end
        if (a_fact) begin
            n_fc = (r_fc == r_wm1) ? '0 : r_fc + CW'(1);
            n_fr = (r_fc == r_wm1) ? r_fr + 12'd1 : r_fr;
        end
        if (a_last) begin
            n_n  = '0;
            n_nc = '0;
            n_gc = '0;
            n_gr = '0;
            n_fc = '0;
            n_fr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_nc <= '0;
            r_gc <= '0;
            r_gr <= '0;
            r_fc <= '0;
            r_fr <= '0;
        end else if (a_proc) begin
            r_n  <= n_n;
            r_nc <= n_nc;
            r_gc <= n_gc;
            r_gr <= n_gr;
            r_fc <= n_fc;
            r_fr <= n_fr;
        end
    end

    // Stage A -> B registers
    logic                   r_b_pix, r_b_gcomp;
    logic signed [DW-1:0]   r_b_d;
    logic [CW-1:0]          r_b_nc, r_b_gc;
    gfs_pkg::t_border       r_b_gb;
    gfs_pkg::t_flux_meta    r_b_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= a_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_proc) begin
            r_b_pix              <= a_pix;
            r_b_gcomp            <= a_gcomp;
            r_b_d                <= i_in.payload.distance_value;
            r_b_nc               <= r_nc;
            r_b_gc               <= r_gc;
            r_b_gb.left          <= r_gc == '0;
            r_b_gb.right         <= r_gc == r_wm1;
            r_b_gb.top           <= r_gr == '0;
            r_b_gb.bottom        <= r_gr == r_hm1;
            r_b_meta.emit        <= a_fact;
            r_b_meta.last        <= a_last;
            r_b_meta.x           <= 10'(r_fc);
            r_b_meta.y           <= r_fr;
            r_b_meta.border.left   <= r_fc == '0;
            r_b_meta.border.right  <= r_fc == r_wm1;
            r_b_meta.border.top    <= r_fr == '0;
            r_b_meta.border.bottom <= r_fr == r_hm1;
        end
    end

    // Line memories: each entry holds the two previous rows of one column
    logic [2*DW-1:0] d_rdata, d_wdata;
    logic [4*GW-1:0] g_rdata, g_wdata;
    logic            d_we, g_we;

    gfs_ram #(.WIDTH(2 * DW), .DEPTH(MAX_WIDTH)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_b_nc),
        .i_wdata (d_wdata),
        .i_re    (a_proc),
        .i_raddr (r_nc),
        .o_rdata (d_rdata)
    );

    gfs_ram #(.WIDTH(4 * GW), .DEPTH(MAX_WIDTH)) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (r_b_gc),
        .i_wdata (g_wdata),
        .i_re    (a_proc),
        .i_raddr (r_gc),
        .o_rdata (g_rdata)
    );

    // -----------------------------------------------------------------------
    // Stage B: distance window and Sobel gradient
    // -----------------------------------------------------------------------
    gfs_pkg::t_dcol r_dl, r_dc, b_col;
    logic signed [DW-1:0] b_c, v0, v1, v2, v3, v4, v5, v6, v7;
    logic signed [GW-1:0] b_gx, b_gy;
    gfs_pkg::t_grad b_ghi, b_glo, b_gnew;

    always_comb begin
        b_col.top = d_rdata[DW-1:0];
        b_col.mid = d_rdata[2*DW-1:DW];
        b_col.bot = r_b_d;
        b_c = r_dc.mid;
        // Outside neighbors take the center value
        v0 = (r_b_gb.left | r_b_gb.top)     ? b_c : r_dl.top;
        v1 = r_b_gb.top                     ? b_c : r_dc.top;
        v2 = (r_b_gb.right | r_b_gb.top)    ? b_c : b_col.top;
        v3 = r_b_gb.left                    ? b_c : r_dl.mid;
        v4 = r_b_gb.right                   ? b_c : b_col.mid;
        v5 = (r_b_gb.left | r_b_gb.bottom)  ? b_c : r_dl.bot;
        v6 = r_b_gb.bottom                  ? b_c : r_dc.bot;
        v7 = (r_b_gb.right | r_b_gb.bottom) ? b_c : b_col.bot;
        b_gx = GW'(v2) + (GW'(v4) <<< 1) + GW'(v7) - GW'(v0) - (GW'(v3) <<< 1) - GW'(v5);
        b_gy = GW'(v5) + (GW'(v6) <<< 1) + GW'(v7) - GW'(v0) - (GW'(v1) <<< 1) - GW'(v2);
        b_gnew.gx = b_gx;
        b_gnew.gy = b_gy;
        b_ghi = gfs_pkg::t_grad'(g_rdata[4*GW-1:2*GW]);
        b_glo = gfs_pkg::t_grad'(g_rdata[2*GW-1:0]);
    end

    assign d_we    = r_b_v & r_b_pix;
    assign d_wdata = {r_b_d, b_col.mid};
    assign g_we    = r_b_v & r_b_gcomp;
    assign g_wdata = {b_gnew, b_ghi};

    gfs_pkg::t_gcol      r_c_col;
    gfs_pkg::t_flux_meta r_c_meta;

    always_ff @(posedge i_clk) begin
        if (r_b_v) begin
            r_dl         <= r_dc;
            r_dc         <= b_col;
            r_c_col.top  <= b_glo;
            r_c_col.mid  <= b_ghi;
            r_c_col.bot  <= b_gnew;
            r_c_meta     <= r_b_meta;
        end
    end

    // -----------------------------------------------------------------------
    // Stage C: gradient window, axis and diagonal flux sums
    // -----------------------------------------------------------------------
    localparam int SW = 23;
    gfs_pkg::t_gcol r_gl, r_gm;
    gfs_pkg::t_border cb;
    logic signed [SW-1:0] c_a, c_b;

    function automatic logic signed [SW-1:0] sx(logic signed [GW-1:0] v, logic off);
        return off ? '0 : SW'(v);
    endfunction

    always_comb begin
        cb  = r_c_meta.border;
        c_a = sx(r_c_col.mid.gx, cb.right) - sx(r_gl.mid.gx, cb.left)
            + sx(r_gm.bot.gy, cb.bottom) - sx(r_gm.top.gy, cb.top);
        c_b = - sx(r_gl.top.gx, cb.left | cb.top) - sx(r_gl.top.gy, cb.left | cb.top)
              + sx(r_c_col.top.gx, cb.right | cb.top)
              - sx(r_c_col.top.gy, cb.right | cb.top)
              - sx(r_gl.bot.gx, cb.left | cb.bottom)
              + sx(r_gl.bot.gy, cb.left | cb.bottom)
              + sx(r_c_col.bot.gx, cb.right | cb.bottom)
              + sx(r_c_col.bot.gy, cb.right | cb.bottom);
    end

    logic signed [SW-1:0] r_d_a, r_d_b;
    gfs_pkg::t_flux_meta  r_d_meta;

    always_ff @(posedge i_clk) begin
        if (r_c_v) begin
            r_gl     <= r_gm;
            r_gm     <= r_c_col;
            r_d_a    <= c_a;
            r_d_b    <= c_b;
            r_d_meta <= r_c_meta;
        end
    end

    // -----------------------------------------------------------------------
    // Stage D: diagonal sum times sqrt2
    // -----------------------------------------------------------------------
    logic signed [55:0]  r_e_p;
    logic signed [SW-1:0] r_e_a;
    gfs_pkg::t_flux_meta r_e_meta;

    always_ff @(posedge i_clk) begin
        if (r_d_v) begin
            r_e_p    <= 56'(r_d_b) * 56'(gfs_pkg::SQRT2_Q31);
            r_e_a    <= r_d_a;
            r_e_meta <= r_d_meta;
        end
    end

    // -----------------------------------------------------------------------
    // Stage E: round, add, saturate
    // -----------------------------------------------------------------------
    logic signed [55:0] e_rnd;
    logic signed [27:0] e_sum;
    gfs_pkg::t_result   e_res;

    always_comb begin
        e_rnd = (r_e_p + 56'sd536870912) >>> 30;
        e_sum = 28'(e_rnd) + (28'(r_e_a) <<< 2);
        if (e_sum > 28'sd8388607) begin
            e_res.flux_value = 24'sh7FFFFF;
        end else if (e_sum < -28'sd8388608) begin
            e_res.flux_value = 24'sh800000;
        end else begin
            e_res.flux_value = 24'(e_sum);
        end
        e_res.pixel_x       = r_e_meta.x;
        e_res.pixel_y       = r_e_meta.y;
        e_res.last_of_frame = r_e_meta.last;
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    // -----------------------------------------------------------------------
    // Output queue
    // -----------------------------------------------------------------------
    gfs_pkg::t_result r_q [gfs_pkg::OUT_DEPTH];
    logic [QW-1:0]    r_wp, r_rp;
    logic             q_push, q_pop;

    assign q_push = r_e_v & r_e_meta.emit;
    assign q_pop  = o_out.valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (q_push) begin
                r_wp <= r_wp + QW'(1);
            end
            if (q_pop) begin
                r_rp <= r_rp + QW'(1);
            end
            r_cnt <= r_cnt + (QW+1)'(q_push) - (QW+1)'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= e_res;
        end
    end

    assign o_out.valid   = r_cnt != '0;
    assign o_out.payload = r_q[r_rp];

endmodule

// ----- rtl/gfs_checker.sv -----
// ---------------------------------------------------------------------------
// gfs_checker
// Port-level checks of the gradient flux stencil, bound to the top level.
// ---------------------------------------------------------------------------
module gfs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input gfs_pkg::t_result i_out_payload
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // Reset empties the output queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Empty pipeline takes requests right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

    // Frame end lies at least at the third row and column
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.last_of_frame |->
            (i_out_payload.pixel_x >= 10'd2) && (i_out_payload.pixel_y >= 12'd2))
        else $error("frame end at impossible position");

endmodule

bind gradient_flux_stencil gfs_checker u_gfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
